// ===== rtl/lru_pr_pkg.sv =====
// Shared types and constants for the LRU page replacement core.
`default_nettype none
package lru_pr_pkg;

	localparam int PAGE_W    = 16;
	localparam int LIMIT_W   = 4;
	localparam int FCOUNT_W  = 32;
	localparam int IN_DATA_W = 16;
	localparam int OUT_W     = 1 + 1 + PAGE_W + FCOUNT_W;
	localparam int OUT_DATA_W = ((OUT_W + 7) / 8) * 8;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd8;

	// per-request control broadcast to every cell
	typedef struct packed {
		logic load;   // request accepted this cycle
		logic evict;  // fault with the store full: bottom entry drops out
	} cell_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/lru_pr_cell.sv =====
// One slot of the recency stack: compares, and shifts down from its upper neighbor.
`default_nettype none
module lru_pr_cell #(
	parameter int SW = 16
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire lru_pr_pkg::cell_ctl_t  ctl,
	input  wire logic [SW-1:0]          key,
	input  wire logic [SW-1:0]          page_in,
	input  wire logic                   valid_in,
	input  wire logic                   go_in,
	output logic [SW-1:0]               page_out,
	output logic                        valid_out,
	output logic                        go_out
);

	logic [SW-1:0] page_q;
	logic          valid_q;
	logic          match;
	logic          shift;

	assign match     = valid_q & (page_q == key);
	assign go_out    = go_in & ~match;
	// no hit above this slot, and the slot lies inside the span being pushed down
	assign shift     = ctl.load & go_in & (ctl.evict ? valid_q : valid_in);
	assign page_out  = page_q;
	assign valid_out = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (shift) begin
			valid_q <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			page_q <= page_in;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/lru_page_replacement_core.sv =====
// Top level of the fully associative LRU page replacement core.
//
// Takes one page reference per cycle while held results are taken, and
// returns one registered result per reference: fault flag, evicted page and a
// saturating fault count. The recency stack is a chain of MAX_FRAMES cells,
// most recent at the head; the hit search ripples down that chain in the
// accepting cycle, so its length sets the clock period rather than the
// throughput. The result register frees as it is taken, so a new request is
// accepted in the same cycle a held result leaves. No clearing pass follows
// reset. resident_limit may be written only while idle; zero acts as one and
// values above MAX_FRAMES act as MAX_FRAMES.
`default_nettype none
module lru_page_replacement_core #(
	parameter int MAX_FRAMES = 8,
	parameter int PAGE_BITS  = 16
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [lru_pr_pkg::LIMIT_W-1:0]      cfg_wdata,    // resident_limit
	input  wire logic                                s_axis_tvalid,
	output logic                                     s_axis_tready,
	input  wire logic [lru_pr_pkg::IN_DATA_W-1:0]    s_axis_tdata, // [15:0] page_number
	output logic                                     m_axis_tvalid,
	input  wire logic                                m_axis_tready,
	// [0] fault, [1] evicted_valid, [17:2] evicted_page, [49:18] fault_count, rest zero
	output logic [lru_pr_pkg::OUT_DATA_W-1:0]        m_axis_tdata
);

	localparam int SW    = (PAGE_BITS < lru_pr_pkg::PAGE_W) ? PAGE_BITS : lru_pr_pkg::PAGE_W;
	localparam int CW    = $clog2(MAX_FRAMES + 1);
	localparam int CMP_W = ((CW > lru_pr_pkg::LIMIT_W) ? CW : lru_pr_pkg::LIMIT_W) + 1;
	localparam int PAD_W = lru_pr_pkg::OUT_DATA_W - lru_pr_pkg::OUT_W;

	logic [lru_pr_pkg::LIMIT_W-1:0]  limit_q;
	logic [CW-1:0]                   count_q;
	logic [lru_pr_pkg::FCOUNT_W-1:0] fault_total_q;

	logic                            out_valid_q;
	logic                            fault_q;
	logic                            ev_valid_q;
	logic [lru_pr_pkg::PAGE_W-1:0]   ev_page_q;

	logic [SW-1:0]                   key;
	logic [SW-1:0]                   page_chain  [MAX_FRAMES+1];
	logic                            valid_chain [MAX_FRAMES+1];
	logic                            go_chain    [MAX_FRAMES+1];
	logic                            accept;
	logic                            miss;
	logic                            evict;
	logic [CMP_W-1:0]                lim_ext;
	logic [CMP_W-1:0]                eff_lim;
	logic [SW-1:0]                   bottom_page;
	lru_pr_pkg::cell_ctl_t           ctl;

	assign key    = s_axis_tdata[SW-1:0];
	assign accept = s_axis_tvalid & s_axis_tready;
	assign s_axis_tready = ~out_valid_q | m_axis_tready;

	assign page_chain[0]  = key;
	assign valid_chain[0] = 1'b1;
	assign go_chain[0]    = 1'b1;

	generate
		for (genvar i = 0; i < MAX_FRAMES; i++) begin : g_cell
			lru_pr_cell #(.SW(SW)) u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.ctl       (ctl),
				.key       (key),
				.page_in   (page_chain[i]),
				.valid_in  (valid_chain[i]),
				.go_in     (go_chain[i]),
				.page_out  (page_chain[i+1]),
				.valid_out (valid_chain[i+1]),
				.go_out    (go_chain[i+1])
			);
		end
	endgenerate

	always_comb begin
		lim_ext = CMP_W'(limit_q);
		if (limit_q == '0) begin
			eff_lim = CMP_W'(1);
		end else if (lim_ext > CMP_W'(MAX_FRAMES)) begin
			eff_lim = CMP_W'(MAX_FRAMES);
		end else begin
			eff_lim = lim_ext;
		end
	end

	assign miss  = go_chain[MAX_FRAMES];
	assign evict = miss & (CMP_W'(count_q) >= eff_lim);
	assign ctl   = '{load: accept, evict: evict};

	// last valid slot is the least recent page
	always_comb begin
		bottom_page = '0;
		for (int i = 1; i <= MAX_FRAMES; i++) begin
			if (valid_chain[i] && (i == MAX_FRAMES || !valid_chain[(i < MAX_FRAMES) ? i + 1 : i]))
				bottom_page = bottom_page | page_chain[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= lru_pr_pkg::LIMIT_RESET;
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q       <= '0;
			fault_total_q <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (accept) begin
				out_valid_q <= 1'b1;
				if (miss) begin
					if (fault_total_q != '1)
						fault_total_q <= fault_total_q + 1'b1;
					if (!evict)
						count_q <= count_q + 1'b1;
				end
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			fault_q    <= miss;
			ev_valid_q <= evict;
			ev_page_q  <= evict ? lru_pr_pkg::PAGE_W'(bottom_page) : '0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{PAD_W{1'b0}}, fault_total_q, ev_page_q, ev_valid_q, fault_q};

endmodule
`default_nettype wire
